/* hw/rtl/gwm_pkg.sv */
// Shared types, constants and helpers for the glob wildcard matcher.
// No dependencies; every other file in hw/rtl except gwm_checker imports this package.
package gwm_pkg;

    // Pattern capacity and derived widths
    localparam int PATTERN_MAX = 32;
    localparam int POS_W       = PATTERN_MAX + 1;
    localparam int LEN_W       = $clog2(PATTERN_MAX + 1);
    localparam int BYTE_W      = 8;
    localparam int OP_W        = 2;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Special pattern characters
    localparam logic [BYTE_W-1:0] CH_ANY = 8'h3F;  // '?'
    localparam logic [BYTE_W-1:0] CH_RUN = 8'h2A;  // '*'

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_TEXT   = 2'd2,
        OP_EMPTY  = 2'd3
    } t_op;

    // Classified command as it travels through the queue
    typedef struct packed {
        t_op               op;
        logic [BYTE_W-1:0] chr;      // lower-case folded byte
        logic              is_star;
        logic              is_any;
        logic              last;
    } t_cmd;

    // One queue port: beat valid plus command
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_beat;

    // ASCII upper case to lower case
    function automatic logic [BYTE_W-1:0] fold(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage

/* hw/rtl/gwm_channels.sv */
// Valid/ready channel interfaces for the matcher's input and result beats.
// Depends on gwm_pkg for field widths.
interface gwm_in_if import gwm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [BYTE_W-1:0] byte_value;
    logic              last;

    modport source (output valid, op, byte_value, last, input ready);
    modport sink   (input valid, op, byte_value, last, output ready);
endinterface

interface gwm_out_if;
    logic valid;
    logic ready;
    logic matched;
    logic pattern_overflow;

    modport source (output valid, matched, pattern_overflow, input ready);
    modport sink   (input valid, matched, pattern_overflow, output ready);
endinterface

/* hw/rtl/gwm_front.sv */
// Front end: takes input beats, decodes the op and folds the byte.
// Depends on gwm_pkg and gwm_in_if.
module gwm_front import gwm_pkg::*; (
    gwm_in_if.sink  i_in,
    input  logic    i_full,
    output t_beat   o_push
);

    // Accept whenever the queue has room
    assign i_in.ready = !i_full;

    // Classify the beat for the back end
    always_comb begin
        o_push.valid       = i_in.valid && !i_full;
        o_push.cmd.op      = t_op'(i_in.op);
        o_push.cmd.chr     = fold(i_in.byte_value);
        o_push.cmd.is_star = (i_in.byte_value == CH_RUN);
        o_push.cmd.is_any  = (i_in.byte_value == CH_ANY);
        o_push.cmd.last    = i_in.last;
    end

endmodule

/* hw/rtl/gwm_queue.sv */
// Short command FIFO that decouples the front end from the back end.
// Depends on gwm_pkg.
module gwm_queue import gwm_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_beat i_push,
    output logic  o_full,
    output t_beat o_pop,
    input  logic  i_pop_ready
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr, n_wptr;
    logic [QPTR_W-1:0] r_rptr, n_rptr;
    logic [QCNT_W-1:0] r_count, n_count;
    logic              push, pop;

    assign o_full        = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_pop.valid   = (r_count != '0);
    assign o_pop.cmd     = r_mem[r_rptr];
    assign push          = i_push.valid && !o_full;
    assign pop           = o_pop.valid && i_pop_ready;

    // Pointer and fill tracking
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (push) begin
            n_wptr = (r_wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (pop) begin
            n_rptr = (r_rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_push.cmd;
        end
    end

endmodule

/* hw/rtl/gwm_back.sv */
// Back end: holds the pattern, advances the live-position set per text byte
// and registers results. Depends on gwm_pkg and gwm_out_if.
module gwm_back import gwm_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_beat         i_pop,
    output logic          o_pop_ready,
    gwm_out_if.source     o_out
);

    // Pattern store (read at fixed places, masked by length)
    logic [BYTE_W-1:0] r_chr [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] r_star;
    logic [PATTERN_MAX-1:0] r_any;

    logic [LEN_W-1:0] r_len, n_len;
    logic             r_ovf, n_ovf;
    logic [POS_W-1:0] r_live, n_live;
    logic [POS_W-1:0] r_start, n_start;   // live set before any text byte
    logic             r_in_text, n_in_text;
    logic             r_out_valid, n_out_valid;
    logic             r_matched, n_matched;
    logic             r_out_ovf, n_out_ovf;

    logic             pop;
    logic             room;
    t_cmd             cmd;
    logic [POS_W-1:0] star_m;
    logic [POS_W-1:0] base;
    logic [POS_W-1:0] step;
    logic [POS_W-1:0] gen;
    logic [POS_W-1:0] carry;
    logic [POS_W-1:0] nxt;
    logic [PATTERN_MAX-1:0] lit_ok;

    assign cmd         = i_pop.cmd;
    assign o_pop_ready = !r_out_valid || o_out.ready;
    assign pop         = i_pop.valid && o_pop_ready;
    assign room        = (r_len < LEN_W'(PATTERN_MAX));

    assign o_out.valid            = r_out_valid;
    assign o_out.matched          = r_matched;
    assign o_out.pattern_overflow = r_out_ovf;

    // Per-position compare and shift of the live set
    always_comb begin
        star_m = '0;
        lit_ok = '0;
        step   = '0;
        base   = r_in_text ? r_live : r_start;
        for (int i = 0; i < PATTERN_MAX; i++) begin
            star_m[i] = (LEN_W'(i) < r_len) && r_star[i];
            lit_ok[i] = (LEN_W'(i) < r_len) && !r_star[i]
                        && (r_any[i] || (r_chr[i] == cmd.chr));
        end
        for (int i = 0; i < PATTERN_MAX; i++) begin
            step[i]   = step[i]   | (base[i] & star_m[i]);
            step[i+1] = step[i+1] | (base[i] & lit_ok[i]);
        end
        // Star closure: carries ripple through runs of stars
        gen   = step & star_m;
        carry = (star_m + gen) ^ star_m ^ gen;
        nxt   = step | carry;
    end

    // Command execution
    always_comb begin
        n_len       = r_len;
        n_ovf       = r_ovf;
        n_live      = r_live;
        n_start     = r_start;
        n_in_text   = r_in_text;
        n_out_valid = r_out_valid && !o_out.ready;
        n_matched   = r_matched;
        n_out_ovf   = r_out_ovf;
        if (pop) begin
            case (cmd.op)
                OP_CLEAR: begin
                    n_len     = '0;
                    n_ovf     = 1'b0;
                    n_live    = '0;
                    n_in_text = 1'b0;
                    n_start   = POS_W'(1);
                end
                OP_APPEND: begin
                    n_live    = '0;
                    n_in_text = 1'b0;
                    if (room) begin
                        n_len = r_len + 1'b1;
                        for (int i = 0; i < PATTERN_MAX; i++) begin
                            if (r_len == LEN_W'(i) && cmd.is_star && r_start[i]) begin
                                n_start[i+1] = 1'b1;
                            end
                        end
                    end else begin
                        n_ovf = 1'b1;
                    end
                end
                OP_EMPTY: begin
                    n_live      = '0;
                    n_in_text   = 1'b0;
                    n_out_valid = 1'b1;
                    n_matched   = r_start[r_len];
                    n_out_ovf   = r_ovf;
                end
                OP_TEXT: begin
                    if (cmd.last) begin
                        n_live      = '0;
                        n_in_text   = 1'b0;
                        n_out_valid = 1'b1;
                        n_matched   = nxt[r_len];
                        n_out_ovf   = r_ovf;
                    end else begin
                        n_live    = nxt;
                        n_in_text = 1'b1;
                    end
                end
                default: begin
                    n_live = r_live;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_ovf       <= 1'b0;
            r_live      <= '0;
            r_start     <= POS_W'(1);
            r_in_text   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_len       <= n_len;
            r_ovf       <= n_ovf;
            r_live      <= n_live;
            r_start     <= n_start;
            r_in_text   <= n_in_text;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        r_matched <= n_matched;
        r_out_ovf <= n_out_ovf;
    end

    // Pattern byte write at the current length
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < PATTERN_MAX; i++) begin
            if (pop && cmd.op == OP_APPEND && room && r_len == LEN_W'(i)) begin
                r_chr[i]  <= cmd.chr;
                r_star[i] <= cmd.is_star;
                r_any[i]  <= cmd.is_any;
            end
        end
    end

endmodule

/* hw/rtl/glob_wildcard_matcher.sv */
// Glob matcher top level: front end, command queue, back end.
// A result beat is registered in the back end after the text's last beat leaves the queue.
// Throughput: one input beat per cycle; the back end retires one command per cycle.
// Sustained rate holds while the result register is drained each cycle.
// Reset (synchronous, active low) empties the queue and the pattern and drops
// any text in progress; pattern bytes themselves are not cleared.
module glob_wildcard_matcher import gwm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    gwm_in_if.sink     i_in,
    gwm_out_if.source  o_out
);

    t_beat push;
    t_beat pop;
    logic  full;
    logic  pop_ready;

    gwm_front u_front (
        .i_in   (i_in),
        .i_full (full),
        .o_push (push)
    );

    gwm_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .o_pop       (pop),
        .i_pop_ready (pop_ready)
    );

    gwm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop       (pop),
        .o_pop_ready (pop_ready),
        .o_out       (o_out)
    );

endmodule

/* hw/rtl/gwm_checker.sv */
// Port-level checks for glob_wildcard_matcher, bound to the top level.
// Depends on the top level's channel ports only.
module gwm_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_out_matched,
    input logic i_out_ovf
);

    // No result beat straight after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result offered after reset");

    // A stalled result stays offered and unchanged
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_matched)
        && $stable(i_out_ovf))
        else $error("stalled result dropped or changed");

    // The input is only held off while a result beat waits
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("input stalled with no result waiting");

endmodule

bind glob_wildcard_matcher gwm_checker u_gwm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_matched (o_out.matched),
    .i_out_ovf     (o_out.pattern_overflow)
);

/* dv/tb_glob_wildcard_matcher.sv */
// Self-checking testbench for glob_wildcard_matcher: directed and random command
// beats, with a bit-parallel predictor of the matcher checking every result beat.
// Depends on gwm_pkg and the gwm_in_if / gwm_out_if channel interfaces.
module tb_glob_wildcard_matcher;
    timeunit 1ns;
    timeprecision 1ps;
    import gwm_pkg::*;

    typedef struct packed {
        t_op               op;
        logic [BYTE_W-1:0] chr;
        logic              last;
    } t_stim;

    typedef struct packed {
        logic matched;
        logic ovf;
    } t_verdict;

    logic i_clk = 1'b0;
    logic i_rst_n;

    gwm_in_if  in_if ();
    gwm_out_if out_if ();

    glob_wildcard_matcher u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #1 i_clk = ~i_clk;

    // Pending command beats and expected result beats
    t_stim    stim_q[$];
    t_verdict verdict_q[$];
    int unsigned stim_total;
    int unsigned n_fail = 0;

    // Predictor state: stored pattern, overflow, live positions
    logic [BYTE_W-1:0] pat_mem [PATTERN_MAX];
    int unsigned       pat_len;
    logic              pat_ovf;
    logic [POS_W-1:0]  live;
    logic              mid_text;

    function automatic logic [BYTE_W-1:0] to_lower(input logic [BYTE_W-1:0] c);
        if (c >= 8'h41 && c <= 8'h5A) return c | 8'h20;
        return c;
    endfunction

    // a live position on a star also makes the next one live
    function automatic logic [POS_W-1:0] star_closure(input logic [POS_W-1:0] s);
        for (int i = 0; i < pat_len; i++) begin
            if (s[i] && pat_mem[i] == CH_RUN) s[i+1] = 1'b1;
        end
        return s;
    endfunction

    function automatic logic [POS_W-1:0] text_advance(input logic [POS_W-1:0] s,
                                                      input logic [BYTE_W-1:0] c);
        logic [POS_W-1:0] nxt;
        nxt = '0;
        for (int i = 0; i < pat_len; i++) begin
            if (s[i]) begin
                if (pat_mem[i] == CH_RUN) begin
                    nxt[i] = 1'b1;
                end else if (pat_mem[i] == CH_ANY || to_lower(pat_mem[i]) == to_lower(c)) begin
                    nxt[i+1] = 1'b1;
                end
            end
        end
        return star_closure(nxt);
    endfunction

    // Predict the effect of one accepted command beat
    task automatic glob_step(input t_op op, input logic [BYTE_W-1:0] chr, input logic last);
        logic [POS_W-1:0] start;
        start = POS_W'(1);
        case (op)
            OP_CLEAR: begin
                pat_len  = 0;
                pat_ovf  = 1'b0;
                live     = '0;
                mid_text = 1'b0;
            end
            OP_APPEND: begin
                mid_text = 1'b0;
                live     = '0;
                if (pat_len < PATTERN_MAX) begin
                    pat_mem[pat_len] = chr;
                    pat_len++;
                end else begin
                    pat_ovf = 1'b1;
                end
            end
            OP_EMPTY: begin
                mid_text = 1'b0;
                live     = '0;
                start    = star_closure(start);
                verdict_q.insert(verdict_q.size(), t_verdict'{start[pat_len], pat_ovf});
            end
            default: begin
                if (!mid_text) live = star_closure(start);
                live     = text_advance(live, chr);
                mid_text = 1'b1;
                if (last) begin
                    verdict_q.insert(verdict_q.size(), t_verdict'{live[pat_len], pat_ovf});
                    mid_text = 1'b0;
                    live     = '0;
                end
            end
        endcase
    endtask

    // Per-beat wait, zero throughout a burst stretch
    function automatic int unsigned pick_wait(input bit burst);
        if (burst) return 0;
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return $urandom_range(1, 3);
            default: return $urandom_range(0, 16);
        endcase
    endfunction

    // Driver: offers queued command beats, predicts on acceptance
    int unsigned feed_gap;
    int unsigned feed_beats;
    bit          feed_burst = 1'b0;

    always @(posedge i_clk) begin
        t_stim nxt;
        logic  offer;
        if (!i_rst_n) begin
            in_if.valid      <= 1'b0;
            in_if.op         <= OP_CLEAR;
            in_if.byte_value <= '0;
            in_if.last       <= 1'b0;
            feed_gap   = 0;
            feed_beats = 0;
            pat_len    = 0;
            pat_ovf    = 1'b0;
            live       = '0;
            mid_text   = 1'b0;
        end else begin
            offer = in_if.valid;
            if (in_if.valid && in_if.ready) begin
                glob_step(t_op'(in_if.op), in_if.byte_value, in_if.last);
                feed_beats++;
                if (feed_beats % 64 == 0) feed_burst = ($urandom_range(0, 2) == 0);
                feed_gap = pick_wait(feed_burst);
                offer = 1'b0;
            end else if (!offer && feed_gap != 0) begin
                feed_gap--;
            end
            if (!offer && feed_gap == 0 && stim_q.size() != 0) begin
                nxt = stim_q.pop_front();
                in_if.op         <= nxt.op;
                in_if.byte_value <= nxt.chr;
                in_if.last       <= nxt.last;
                offer = 1'b1;
            end
            in_if.valid <= offer;
        end
    end

    // Long receiver hold-off so the queue fills and back-pressures the input
    int unsigned clk_count;
    int unsigned hold_left;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clk_count <= 0;
            hold_left <= 0;
        end else begin
            clk_count <= clk_count + 1;
            if (clk_count == 500 || clk_count == 4000) begin
                hold_left <= 200;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
            end
        end
    end

    // Monitor: checks each result beat against the oldest expectation
    int unsigned drain_stall;
    int unsigned results_seen;
    bit          drain_burst = 1'b0;

    always @(posedge i_clk) begin
        t_verdict want;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            drain_stall  = 0;
            results_seen = 0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (verdict_q.size() == 0) begin
                    $display("%0t: unexpected result beat matched=%0b overflow=%0b", $time,
                             out_if.matched, out_if.pattern_overflow);
                    n_fail++;
                end else begin
                    want = verdict_q.pop_front();
                    if (out_if.matched !== want.matched) begin
                        $display("%0t: matched mismatch: expected %0b, actual %0b", $time,
                                 want.matched, out_if.matched);
                        n_fail++;
                    end
                    if (out_if.pattern_overflow !== want.ovf) begin
                        $display("%0t: pattern_overflow mismatch: expected %0b, actual %0b",
                                 $time, want.ovf, out_if.pattern_overflow);
                        n_fail++;
                    end
                end
                results_seen++;
                if (results_seen % 32 == 0) drain_burst = ($urandom_range(0, 2) == 0);
                drain_stall = pick_wait(drain_burst);
            end else if (drain_stall != 0) begin
                drain_stall--;
            end
            out_if.ready <= (drain_stall == 0) && (hold_left == 0);
        end
    end

    // Stimulus building
    logic [BYTE_W-1:0] gen_pat[$];  // stored pattern as the generator sees it

    task automatic put(input t_op op, input logic [BYTE_W-1:0] chr, input logic last);
        t_stim s;
        s.op   = op;
        s.chr  = chr;
        s.last = last;
        stim_q.insert(stim_q.size(), s);
    endtask

    function automatic logic [BYTE_W-1:0] rand_byte();
        return BYTE_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [BYTE_W-1:0] pattern_char();
        case ($urandom_range(0, 9))
            0, 1:    return CH_RUN;
            2:       return CH_ANY;
            3:       return rand_byte();
            default: return BYTE_W'($urandom_range(0, 3)) +
                            ($urandom_range(0, 1) ? 8'h41 : 8'h61);
        endcase
    endfunction

    function automatic logic [BYTE_W-1:0] text_filler();
        case ($urandom_range(0, 5))
            0:       return CH_RUN;
            1:       return rand_byte();
            default: return 8'h61 + BYTE_W'($urandom_range(0, 3));
        endcase
    endfunction

    task automatic add_pattern_byte();
        logic [BYTE_W-1:0] c;
        c = pattern_char();
        put(OP_APPEND, c, 1'($urandom_range(0, 1)));
        if (gen_pat.size() < PATTERN_MAX) gen_pat.insert(gen_pat.size(), c);
    endtask

    task automatic load_pattern(input int unsigned n, input bit wipe);
        if (wipe) begin
            put(OP_CLEAR, rand_byte(), 1'($urandom_range(0, 1)));
            gen_pat.delete();
        end
        repeat (n) add_pattern_byte();
    endtask

    // Text built from the pattern, so it mostly matches; optionally damaged
    task automatic send_text(input bit mangle);
        logic [BYTE_W-1:0] txt[$];
        logic [BYTE_W-1:0] c;
        int unsigned       k;
        foreach (gen_pat[i]) begin
            c = gen_pat[i];
            if (c == CH_RUN) begin
                repeat ($urandom_range(0, 3)) txt.insert(txt.size(), text_filler());
            end else if (c == CH_ANY) begin
                txt.insert(txt.size(), rand_byte());
            end else if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) begin
                txt.insert(txt.size(), $urandom_range(0, 1) ? (c ^ 8'h20) : c);
            end else begin
                txt.insert(txt.size(), c);
            end
        end
        if (mangle) begin
            k = $urandom_range(0, txt.size());
            case ($urandom_range(0, 2))
                0: txt.insert(k, text_filler());
                1: if (txt.size() != 0) txt.delete(k % txt.size());
                default: if (txt.size() != 0) txt[k % txt.size()] = rand_byte();
            endcase
        end
        if (txt.size() == 0) begin
            put(OP_EMPTY, rand_byte(), 1'($urandom_range(0, 1)));
        end else begin
            foreach (txt[i]) put(OP_TEXT, txt[i], i == txt.size() - 1);
        end
    endtask

    // Text cut short by an append, a clear or an empty-text query
    task automatic broken_text();
        repeat ($urandom_range(1, 4)) put(OP_TEXT, text_filler(), 1'b0);
        case ($urandom_range(0, 2))
            0: add_pattern_byte();
            1: begin
                put(OP_CLEAR, rand_byte(), 1'($urandom_range(0, 1)));
                gen_pat.delete();
            end
            default: put(OP_EMPTY, rand_byte(), 1'($urandom_range(0, 1)));
        endcase
    endtask

    initial begin
        int unsigned sel;
        int unsigned len;
        int unsigned texts_left;
        bit          wipe;
        bit          gen_stale;
        i_rst_n          = 1'b0;
        in_if.valid      = 1'b0;
        in_if.op         = OP_CLEAR;
        in_if.byte_value = '0;
        in_if.last       = 1'b0;
        out_if.ready     = 1'b0;

        // Directed: empty pattern, star and question mark, case folding,
        // star against star, abandoned texts, clear with junk fields
        put(OP_EMPTY,  8'h00, 1'b0);
        put(OP_TEXT,   8'h00, 1'b1);
        put(OP_APPEND, 8'h41, 1'b0);
        put(OP_APPEND, CH_RUN, 1'b1);
        put(OP_APPEND, CH_ANY, 1'b0);
        put(OP_EMPTY,  8'hFF, 1'b1);
        put(OP_TEXT,   8'h61, 1'b0);
        put(OP_TEXT,   CH_RUN, 1'b0);
        put(OP_TEXT,   8'h5A, 1'b1);
        put(OP_TEXT,   8'h61, 1'b0);
        put(OP_TEXT,   8'hFF, 1'b1);
        put(OP_TEXT,   8'h61, 1'b0);
        put(OP_APPEND, CH_RUN, 1'b0);
        put(OP_TEXT,   8'h41, 1'b0);
        put(OP_EMPTY,  8'h00, 1'b0);
        put(OP_TEXT,   8'h41, 1'b0);
        put(OP_TEXT,   8'h62, 1'b0);
        put(OP_TEXT,   8'h43, 1'b1);
        put(OP_CLEAR,  8'hFF, 1'b1);
        put(OP_EMPTY,  8'h00, 1'b0);
        put(OP_APPEND, CH_RUN, 1'b0);
        put(OP_EMPTY,  8'h00, 1'b0);
        put(OP_TEXT,   CH_ANY, 1'b1);
        put(OP_APPEND, CH_ANY, 1'b0);
        put(OP_TEXT,   8'h80, 1'b1);
        gen_stale  = 1'b1;
        texts_left = 0;

        // Random: mostly patterns followed by texts, some noise and broken texts
        while (stim_q.size() < 1150) begin
            sel = $urandom_range(0, 99);
            if (sel < 5) begin
                repeat ($urandom_range(1, 3)) begin
                    put(t_op'($urandom_range(0, 3)), rand_byte(), 1'($urandom_range(0, 1)));
                end
                gen_stale = 1'b1;
            end else if (texts_left == 0) begin
                wipe = gen_stale || ($urandom_range(0, 5) != 0);
                len  = ($urandom_range(0, 11) == 0) ?
                       $urandom_range(PATTERN_MAX - 1, PATTERN_MAX + 6) : $urandom_range(0, 6);
                load_pattern(len, wipe);
                gen_stale  = 1'b0;
                texts_left = $urandom_range(2, 6);
            end else begin
                texts_left--;
                if (sel < 12) begin
                    broken_text();
                end else if (sel < 20) begin
                    put(OP_EMPTY, rand_byte(), 1'($urandom_range(0, 1)));
                end else begin
                    send_text(sel < 45);
                end
            end
        end
        stim_total = stim_q.size();

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: every beat accepted and every result seen, then a short tail
        while (feed_beats != stim_total || verdict_q.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (n_fail == 0) begin
            $display("tb_glob_wildcard_matcher OK");
        end else begin
            $display("tb_glob_wildcard_matcher NOT OK");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #400_000;
        $display("tb_glob_wildcard_matcher NOT OK");
        $finish;
    end

endmodule
